>>> rtl/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants of the counting semaphore wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

  localparam int ID_W    = 6;
  localparam int NUM_IDS = 1 << ID_W;
  localparam int COUNT_W = 16;
  localparam int CMD_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd2;

  // count limits
  localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 16'sh7fff;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN  = 16'sh8000;
  localparam logic signed [COUNT_W-1:0] COUNT_INIT = 16'sd1;
  localparam logic signed [COUNT_W-1:0] COUNT_ONE  = 16'sd1;

  // one result item
  typedef struct packed {
    logic                      blocked;
    logic                      queued;
    logic                      wake_valid;
    logic [ID_W-1:0]           wake_id;
    logic signed [COUNT_W-1:0] count_now;
  } res_t;

endpackage

>>> rtl/csq_out_buf.sv
// ----------------------------------------------------------------------------
// csq_out_buf
// Two-entry result buffer: an output register plus a skid register, so a
// new item can be taken while a finished result waits on the output.
// ----------------------------------------------------------------------------
module csq_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csq_pkg::res_t push_res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output csq_pkg::res_t out_res
);
  import csq_pkg::*;

  logic v0;
  logic v1;
  res_t r0;
  res_t r1;
  logic pop;

  // output transfer
  assign pop       = v0 && !out_stall;
  assign out_valid = v0;
  assign out_res   = r0;
  assign full      = v1;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        v1 <= push;
      end else begin
        v0 <= push;
      end
    end else if (push) begin
      if (!v0) begin
        v0 <= 1'b1;
      end else begin
        v1 <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1) begin
        r0 <= r1;
        if (push) begin
          r1 <= push_res;
        end
      end else if (push) begin
        r0 <= push_res;
      end
    end else if (push) begin
      if (!v0) begin
        r0 <= push_res;
      end else begin
        r1 <= push_res;
      end
    end
  end

endmodule

>>> rtl/counting_semaphore_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a circular FIFO of waiting thread ids held in a
// synchronous slot memory, and a per-id membership vector for duplicates.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_stall  | cmd, thread_id
//  output  | out_valid/out_stall| blocked, queued, wake_valid, wake_id,
//          |                    | count_now
//
// For each item, the transfer cycle updates count and indices and issues the
// slot memory read, and the next cycle takes the registered read data for the
// wakeup id. One item is in flight at a time; the input stalls while the
// previous item takes its read data.
// Reset sets count to its initial value and clears indices and membership bits at once; no clearing pass.
// A stalled output holds its result; one more result fits in the skid
// register, after which the input stalls until the output drains.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit #(
  parameter int THREADS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [csq_pkg::CMD_W-1:0]          cmd,
  input  logic [csq_pkg::ID_W-1:0]           thread_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               blocked,
  output logic                               queued,
  output logic                               wake_valid,
  output logic [csq_pkg::ID_W-1:0]           wake_id,
  output logic signed [csq_pkg::COUNT_W-1:0] count_now
);
  import csq_pkg::*;

  localparam int SLOTS = THREADS + 1;
  localparam int IW    = $clog2(SLOTS);

  logic signed [COUNT_W-1:0] sem_count;
  logic signed [COUNT_W-1:0] count_next;
  logic [IW-1:0]             front;
  logic [IW-1:0]             back;
  logic [IW-1:0]             front_step;
  logic [IW-1:0]             back_step;
  logic [NUM_IDS-1:0]        member;
  logic                      accept;
  logic                      is_init;
  logic                      do_block;
  logic                      do_queue;
  logic                      do_wake;
  logic                      s1_valid;
  res_t                      s1_res;
  res_t                      push_res;
  res_t                      out_res;
  logic                      buf_full;
  logic [ID_W-1:0]           rd_data;
  logic [ID_W-1:0]           slots [SLOTS];

  // input transfer
  assign in_stall = s1_valid || buf_full;
  assign accept   = in_valid && !in_stall;

  // circular index steps
  assign front_step = (front == IW'(THREADS)) ? '0 : front + 1'b1;
  assign back_step  = (back  == IW'(THREADS)) ? '0 : back  + 1'b1;

  // command decode and count update
  always_comb begin
    count_next = sem_count;
    is_init    = 1'b0;
    do_block   = 1'b0;
    do_queue   = 1'b0;
    do_wake    = 1'b0;
    case (cmd)
      CMD_WAIT: begin
        if (sem_count != COUNT_MIN) begin
          count_next = sem_count - COUNT_ONE;
        end
        do_block = count_next[COUNT_W-1];
        do_queue = do_block && !member[thread_id] && (front != back_step);
      end
      CMD_SIGNAL: begin
        if (sem_count != COUNT_MAX) begin
          count_next = sem_count + COUNT_ONE;
        end
        do_wake = (front != back);
      end
      CMD_INIT: begin
        count_next = COUNT_INIT;
        is_init    = 1'b1;
      end
      default: begin
        count_next = sem_count;
      end
    endcase
  end

  // count, queue indices, membership and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count <= COUNT_INIT;
      front     <= '0;
      back      <= '0;
      member    <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        sem_count <= count_next;
        if (is_init) begin
          front  <= '0;
          back   <= '0;
          member <= '0;
        end
        if (do_queue) begin
          back             <= back_step;
          member[thread_id] <= 1'b1;
        end
        if (do_wake) begin
          front <= front_step;
        end
      end
      // dequeued id leaves the membership set once its slot is read
      if (s1_valid && s1_res.wake_valid) begin
        member[rd_data] <= 1'b0;
      end
    end
  end

  // result fields known in the transfer cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res.blocked    <= do_block;
      s1_res.queued     <= do_queue;
      s1_res.wake_valid <= do_wake;
      s1_res.wake_id    <= '0;
      s1_res.count_now  <= count_next;
    end
  end

  // wait slot memory
  always_ff @(posedge clk) begin
    if (accept && do_queue) begin
      slots[back_step] <= thread_id;
    end
    if (accept && do_wake) begin
      rd_data <= slots[front_step];
    end
  end

  // merge read data into the result
  always_comb begin
    push_res = s1_res;
    if (s1_res.wake_valid) begin
      push_res.wake_id = rd_data;
    end
  end

  csq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_res  (push_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign blocked    = out_res.blocked;
  assign queued     = out_res.queued;
  assign wake_valid = out_res.wake_valid;
  assign wake_id    = out_res.wake_id;
  assign count_now  = out_res.count_now;

endmodule

>>> rtl/csq_checker.sv
// ----------------------------------------------------------------------------
// csq_checker
// Port-level checks on the semaphore wait queue results, bound to the top.
// ----------------------------------------------------------------------------
module csq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [csq_pkg::CMD_W-1:0]          cmd,
  input logic [csq_pkg::ID_W-1:0]           thread_id,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               blocked,
  input logic                               queued,
  input logic                               wake_valid,
  input logic [csq_pkg::ID_W-1:0]           wake_id,
  input logic signed [csq_pkg::COUNT_W-1:0] count_now
);

  // a wait blocks and a signal wakes, never both in one result
  a_block_xor_wake: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(blocked && wake_valid))
    else $error("result both blocks and wakes");

  // an appended id always comes with a blocked waiter and a negative count
  a_queued_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queued) |-> (blocked && count_now[csq_pkg::COUNT_W-1]))
    else $error("id queued without a blocked waiter");

  // no wakeup means a zero wakeup id
  a_wake_id_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wake_valid) |-> (wake_id == '0))
    else $error("wake_id set without wake_valid");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(count_now) && $stable(wake_id)))
    else $error("stalled result changed");

endmodule

bind counting_semaphore_wait_queue_unit csq_checker u_csq_checker (.*);

>>> sim/csq_checker.sv
// ----------------------------------------------------------------------------
// csq_checker
// Watches both channels of the counting semaphore wait queue. It predicts
// every result from its own copy of the count and the wait queue, and
// compares each output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csq_tb_checker #(
  parameter int THREADS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [csq_pkg::CMD_W-1:0]          cmd,
  input  logic [csq_pkg::ID_W-1:0]           thread_id,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               blocked,
  input  logic                               queued,
  input  logic                               wake_valid,
  input  logic [csq_pkg::ID_W-1:0]           wake_id,
  input  logic signed [csq_pkg::COUNT_W-1:0] count_now,
  output int                                 errors,
  output int                                 pending
);
  import csq_pkg::*;

  localparam int SLOTS = THREADS + 1;

  // predicted semaphore state
  logic signed [COUNT_W-1:0] sem_level;
  logic [ID_W-1:0]           waiter_slot [0:SLOTS-1];
  int unsigned               head_pos;
  int unsigned               tail_pos;

  // results still owed by the block, oldest first
  res_t owed_results[$];
  int   result_index;

  function automatic int unsigned next_pos(input int unsigned p);
    return (p + 1) % SLOTS;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got_v,
                                 input logic signed [31:0] want_v);
    $display("csq_tb_checker: result %0d %s got %0d expected %0d",
             result_index, what, got_v, want_v);
    errors++;
  endtask

  // one accepted command: update the state and queue the result it owes
  task automatic predict_semaphore(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id);
    res_t        r;
    int unsigned p;
    bit          already;
    r = '0;
    case (c)
      CMD_WAIT: begin
        if (sem_level != COUNT_MIN) sem_level = sem_level - COUNT_ONE;
        if (sem_level < 0) begin
          r.blocked = 1'b1;
          already = 1'b0;
          p = head_pos;
          while (p != tail_pos) begin
            p = next_pos(p);
            if (waiter_slot[p] == id) already = 1'b1;
          end
          // append only a new id, and only while a slot is free
          if (!already && head_pos != next_pos(tail_pos)) begin
            tail_pos = next_pos(tail_pos);
            waiter_slot[tail_pos] = id;
            r.queued = 1'b1;
          end
        end
      end
      CMD_SIGNAL: begin
        if (sem_level != COUNT_MAX) sem_level = sem_level + COUNT_ONE;
        if (head_pos != tail_pos) begin
          head_pos = next_pos(head_pos);
          r.wake_valid = 1'b1;
          r.wake_id = waiter_slot[head_pos];
        end
      end
      CMD_INIT: begin
        sem_level = COUNT_INIT;
        head_pos = 0;
        tail_pos = 0;
      end
      default: ;
    endcase
    r.count_now = sem_level;
    owed_results.push_back(r);
  endtask

  // one output transfer against the oldest owed result
  task automatic check_result();
    res_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("arrived with nothing owed, count_now", count_now, 0);
      result_index++;
      return;
    end
    want = owed_results.pop_front();
    if (blocked !== want.blocked) report_mismatch("blocked", blocked, want.blocked);
    if (queued !== want.queued) report_mismatch("queued", queued, want.queued);
    if (wake_valid !== want.wake_valid)
      report_mismatch("wake_valid", wake_valid, want.wake_valid);
    if (wake_id !== want.wake_id) report_mismatch("wake_id", wake_id, want.wake_id);
    if (count_now !== want.count_now)
      report_mismatch("count_now", count_now, want.count_now);
    result_index++;
  endtask

  // sample both channels at the edge; output first so a result never meets its own input
  always @(posedge clk) begin
    if (rst) begin
      sem_level = COUNT_INIT;
      head_pos = 0;
      tail_pos = 0;
      owed_results.delete();
      result_index = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_semaphore(cmd, thread_id);
    end
    pending = owed_results.size();
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the counting semaphore wait queue: directed corner commands,
// random episodes of waits and signals and a long output hold-off. The
// checker beside the block judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import csq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 960;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          cmd = CMD_WAIT;
  logic [ID_W-1:0]           thread_id = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      blocked;
  logic                      queued;
  logic                      wake_valid;
  logic [ID_W-1:0]           wake_id;
  logic signed [COUNT_W-1:0] count_now;

  int errors;
  int pending;
  int sent_items;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;

  counting_semaphore_wait_queue_unit #(.THREADS(64)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .thread_id(thread_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .blocked(blocked), .queued(queued), .wake_valid(wake_valid),
    .wake_id(wake_id), .count_now(count_now)
  );

  csq_tb_checker #(.THREADS(64)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .thread_id(thread_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .blocked(blocked), .queued(queued), .wake_valid(wake_valid),
    .wake_id(wake_id), .count_now(count_now),
    .errors(errors), .pending(pending)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("counting_semaphore_wait_queue_unit: mismatch");
    $finish;
  end

  // output side: random stall before each transfer, plus one long hold-off
  initial begin
    int stall_len;
    forever begin
      stall_len = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (hold_request) begin
        stall_len += HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // offer one command after a random gap and hold it until the transfer
  task automatic issue(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    thread_id <= id;
    do @(posedge clk); while (in_stall);
    if (c != CMD_NONE) sent_items++;
  endtask

  function automatic logic [ID_W-1:0] any_id(input int top_id);
    return ID_W'($urandom_range(0, top_id));
  endfunction

  initial begin
    int kind;
    int len;
    int pool;
    int bias;
    int j;
    int swap_v;
    int id_order[NUM_IDS];

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty signal, duplicate waiter, unused command, id extremes
    issue(CMD_SIGNAL, 6'd17);
    issue(CMD_WAIT, 6'd0);
    issue(CMD_WAIT, 6'd63);
    issue(CMD_WAIT, 6'd63);
    issue(CMD_WAIT, 6'd63);
    issue(CMD_WAIT, 6'd0);
    issue(CMD_NONE, 6'd42);
    issue(CMD_WAIT, 6'd21);
    issue(CMD_SIGNAL, 6'd63);
    issue(CMD_SIGNAL, 6'd0);
    issue(CMD_SIGNAL, 6'd42);
    issue(CMD_SIGNAL, 6'd5);
    issue(CMD_WAIT, 6'd42);
    issue(CMD_WAIT, 6'd21);
    issue(CMD_INIT, 6'd63);
    issue(CMD_SIGNAL, 6'd0);
    issue(CMD_NONE, 6'd0);
    issue(CMD_WAIT, 6'd1);
    issue(CMD_WAIT, 6'd62);
    issue(CMD_WAIT, 6'd62);
    issue(CMD_INIT, 6'd0);

    // long hold-off on the output while the input keeps offering
    hold_request = 1'b1;
    tx_idle_on = 1'b0;
    for (int k = 0; k < 30; k++)
      issue($urandom_range(0, 2) == 0 ? CMD_SIGNAL : CMD_WAIT, any_id(63));

    // random episodes
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if (kind <= 4) begin
        // mixed waits and signals over a small or large id pool
        if ($urandom_range(0, 1)) issue(CMD_INIT, any_id(63));
        len = $urandom_range(4, 40);
        pool = $urandom_range(0, 1) ? $urandom_range(1, 7) : 63;
        bias = $urandom_range(30, 80);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < bias) issue(CMD_WAIT, any_id(pool));
          else issue(CMD_SIGNAL, any_id(63));
        end
      end else if (kind <= 6) begin
        // fill the queue with every id, overflow it, then drain it in part or in full
        for (int k = 0; k < NUM_IDS; k++) id_order[k] = k;
        for (int k = NUM_IDS - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          swap_v = id_order[k];
          id_order[k] = id_order[j];
          id_order[j] = swap_v;
        end
        issue(CMD_INIT, any_id(63));
        issue(CMD_WAIT, any_id(63));
        for (int k = 0; k < NUM_IDS; k++) issue(CMD_WAIT, ID_W'(id_order[k]));
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) issue(CMD_WAIT, any_id(63));
        len = $urandom_range(60, 70);
        for (int k = 0; k < len; k++) issue(CMD_SIGNAL, any_id(63));
      end else if (kind == 7) begin
        // noise, unused command included
        for (int k = 0; k < 20; k++) issue(CMD_W'($urandom_range(0, 3)), any_id(63));
      end else begin
        // sequence broken off by a reinitialize
        len = $urandom_range(2, 15);
        for (int k = 0; k < len; k++) issue(CMD_WAIT, any_id(63));
        issue(CMD_INIT, any_id(63));
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) issue(CMD_SIGNAL, any_id(63));
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching for anything stray
    rx_idle_on = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("counting_semaphore_wait_queue_unit: match");
    else
      $display("counting_semaphore_wait_queue_unit: mismatch");
    $finish;
  end

endmodule
